@@ rtl/core/eq3_pkg.sv @@
// Shared types, constants and the microprogram of the three-band equalizer.
`default_nettype none

package eq3_pkg;

  localparam int SLOTS_PER_BAND = 5;
  localparam int HIST_PER_BAND  = 4;
  localparam int UCODE_AW       = 3;

  // coefficient slots within a band
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  // history slots within a band
  localparam logic [1:0] HIST_X1 = 2'd0;
  localparam logic [1:0] HIST_X2 = 2'd1;
  localparam logic [1:0] HIST_Y1 = 2'd2;
  localparam logic [1:0] HIST_Y2 = 2'd3;

  // source of a history write
  typedef enum logic [1:0] {
    HSRC_RD,
    HSRC_X,
    HSRC_Y
  } hsrc_t;

  // sequencing at the end of a control word
  typedef enum logic {
    BR_NEXT,
    BR_BAND
  } branch_t;

  typedef struct packed {
    logic       issue;
    logic       first;
    logic       use_x;
    logic       sub;
    logic [2:0] coef_slot;
    logic [1:0] hist_slot;
    logic       hwr_en;
    logic [1:0] hwr_slot;
    hsrc_t      hwr_src;
    logic       fin;
    branch_t    br;
  } uword_t;

  localparam uword_t UWORD_NOP = '{
    issue: 1'b0, first: 1'b0, use_x: 1'b0, sub: 1'b0,
    coef_slot: SLOT_B0, hist_slot: HIST_X1,
    hwr_en: 1'b0, hwr_slot: HIST_X1, hwr_src: HSRC_RD,
    fin: 1'b0, br: BR_NEXT
  };

  // Per-band program: five taps through the shared multiplier, history
  // shifts slotted into free write cycles, two drain steps, then round.
  function automatic uword_t ucode(input logic [UCODE_AW-1:0] step);
    uword_t w;
    w = UWORD_NOP;
    case (step)
      3'd0: begin
        w.issue = 1'b1; w.first = 1'b1; w.use_x = 1'b1;
        w.coef_slot = SLOT_B0;
      end
      3'd1: begin
        w.issue = 1'b1; w.coef_slot = SLOT_B1; w.hist_slot = HIST_X1;
      end
      3'd2: begin
        w.issue = 1'b1; w.coef_slot = SLOT_B2; w.hist_slot = HIST_X2;
        w.hwr_en = 1'b1; w.hwr_slot = HIST_X2; w.hwr_src = HSRC_RD;
      end
      3'd3: begin
        w.issue = 1'b1; w.sub = 1'b1; w.coef_slot = SLOT_A1; w.hist_slot = HIST_Y1;
        w.hwr_en = 1'b1; w.hwr_slot = HIST_X1; w.hwr_src = HSRC_X;
      end
      3'd4: begin
        w.issue = 1'b1; w.sub = 1'b1; w.coef_slot = SLOT_A2; w.hist_slot = HIST_Y2;
        w.hwr_en = 1'b1; w.hwr_slot = HIST_Y2; w.hwr_src = HSRC_RD;
      end
      3'd7: begin
        w.fin = 1'b1; w.br = BR_BAND;
        w.hwr_en = 1'b1; w.hwr_slot = HIST_Y1; w.hwr_src = HSRC_Y;
      end
      default: begin
        w = UWORD_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/eq3_ram.sv @@
// Generic single-port-write, registered-read RAM (read-first).
`default_nettype none

module eq3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/eq3_seq.sv @@
// Microcode sequencer: step counter, band counter and branch on band end.
`default_nettype none

module eq3_seq #(
  parameter int NUM_BANDS = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   hold,
  output logic                        busy,
  output logic                        done,
  output eq3_pkg::uword_t             ctrl,
  output logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] band
);

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BW-1:0] LAST_BAND = BW'(NUM_BANDS - 1);

  logic                         busy_r, busy_nxt;
  logic [eq3_pkg::UCODE_AW-1:0] step_r, step_nxt;
  logic [BW-1:0]                band_r, band_nxt;

  always_comb begin
    ctrl     = busy_r ? eq3_pkg::ucode(step_r) : eq3_pkg::UWORD_NOP;
    busy_nxt = busy_r;
    step_nxt = step_r;
    band_nxt = band_r;
    done     = 1'b0;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
        band_nxt = '0;
      end
    end else begin
      case (ctrl.br)
        eq3_pkg::BR_BAND: begin
          if (band_r != LAST_BAND) begin
            band_nxt = band_r + 1'b1;
            step_nxt = '0;
          end else if (!hold) begin
            busy_nxt = 1'b0;
            done     = 1'b1;
          end
        end
        default: begin
          step_nxt = step_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      band_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      band_r <= band_nxt;
    end
  end

  assign busy = busy_r;
  assign band = band_r;

endmodule

`default_nettype wire

@@ rtl/core/eq3_dp.sv @@
// Biquad datapath: coefficient and history stores, shared multiplier, accumulator, rounding.
`default_nettype none

module eq3_dp #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_WIDTH     = 28,
  parameter int COEF_FRAC_BITS = 24,
  parameter int NUM_BANDS      = 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire eq3_pkg::uword_t                       ctrl,
  input  wire logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] band,
  input  wire logic                                  start,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  wire logic                                  cw_en,
  input  wire logic [$clog2(NUM_BANDS*eq3_pkg::SLOTS_PER_BAND)-1:0] cw_addr,
  input  wire logic signed [COEF_WIDTH-1:0]          cw_data,
  output logic signed [SAMPLE_WIDTH-1:0]             y_out,
  output logic                                       clip_out
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int F   = COEF_FRAC_BITS;
  localparam int NC  = NUM_BANDS * eq3_pkg::SLOTS_PER_BAND;
  localparam int NH  = NUM_BANDS * eq3_pkg::HIST_PER_BAND;
  localparam int CAW = $clog2(NC);
  localparam int HAW = $clog2(NH);
  localparam int PW  = SW + CW;
  localparam int AW  = PW + 3;
  localparam int EW  = (AW > SW + F + 1) ? AW : SW + F + 1;

  localparam logic signed [EW-1:0] HALF = EW'(1) << (F - 1);
  localparam logic signed [EW-1:0] SHI  = {{(EW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [EW-1:0] SLO  = ~SHI;

  logic [NC-1:0] cval_r;
  logic [NH-1:0] hval_r;
  logic          cv_q_r, hv_q_r;

  logic [CAW-1:0]        c_raddr;
  logic [HAW-1:0]        h_raddr, h_waddr;
  logic [CW-1:0]         c_rdata;
  logic [SW-1:0]         h_rdata;
  logic signed [CW-1:0]  coef_m;
  logic signed [SW-1:0]  hist_m;
  logic signed [SW-1:0]  op_x;
  logic [SW-1:0]         h_wdata;

  logic                  p1_valid_r, p1_first_r, p1_sub_r, p1_usex_r;
  logic                  p2_valid_r, p2_first_r, p2_sub_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [AW-1:0]  acc_r, acc_nxt, prod_x;

  logic signed [SW-1:0]  xin_r;
  logic                  clip_r;
  logic signed [EW-1:0]  acc_e, rnd, shr;
  logic signed [SW-1:0]  y_sat;
  logic                  sat;

  // Store addresses: band*5+slot for coefficients, band*4+slot for history.
  always_comb begin
    c_raddr = CAW'({band, 2'b00}) + CAW'(band) + CAW'(ctrl.coef_slot);
    h_raddr = HAW'({band, ctrl.hist_slot});
    h_waddr = HAW'({band, ctrl.hwr_slot});
  end

  eq3_ram #(.WIDTH(CW), .DEPTH(NC)) u_coef_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  eq3_ram #(.WIDTH(SW), .DEPTH(NH)) u_hist_ram (
    .clk   (clk),
    .we    (ctrl.hwr_en),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Entries never written read as zero.
  assign coef_m = cv_q_r ? $signed(c_rdata) : '0;
  assign hist_m = hv_q_r ? $signed(h_rdata) : '0;
  assign op_x   = p1_usex_r ? xin_r : hist_m;

  // Round half up, then saturate to the sample range.
  always_comb begin
    acc_e = EW'(acc_r);
    rnd   = acc_e + HALF;
    shr   = rnd >>> F;
    sat   = 1'b0;
    if (shr > SHI) begin
      y_sat = SHI[SW-1:0];
      sat   = 1'b1;
    end else if (shr < SLO) begin
      y_sat = SLO[SW-1:0];
      sat   = 1'b1;
    end else begin
      y_sat = shr[SW-1:0];
    end
  end

  always_comb begin
    case (ctrl.hwr_src)
      eq3_pkg::HSRC_X: h_wdata = xin_r;
      eq3_pkg::HSRC_Y: h_wdata = y_sat;
      default:         h_wdata = hist_m;
    endcase
  end

  always_comb begin
    prod_x  = AW'(prod_r);
    acc_nxt = acc_r;
    if (p2_valid_r) begin
      if (p2_first_r) begin
        acc_nxt = p2_sub_r ? -prod_x : prod_x;
      end else begin
        acc_nxt = p2_sub_r ? acc_r - prod_x : acc_r + prod_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cval_r     <= '0;
      hval_r     <= '0;
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      if (cw_en) begin
        cval_r[cw_addr] <= 1'b1;
      end
      if (ctrl.hwr_en) begin
        hval_r[h_waddr] <= 1'b1;
      end
      p1_valid_r <= ctrl.issue;
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cv_q_r     <= cval_r[c_raddr];
    hv_q_r     <= hval_r[h_raddr];
    p1_first_r <= ctrl.first;
    p1_sub_r   <= ctrl.sub;
    p1_usex_r  <= ctrl.use_x;
    p2_first_r <= p1_first_r;
    p2_sub_r   <= p1_sub_r;
    prod_r     <= PW'(coef_m * op_x);
    acc_r      <= acc_nxt;
    if (start) begin
      xin_r  <= sample;
      clip_r <= 1'b0;
    end else if (ctrl.fin) begin
      xin_r  <= y_sat;
      clip_r <= clip_r | sat;
    end
  end

  assign y_out    = y_sat;
  assign clip_out = clip_r | sat;

endmodule

`default_nettype wire

@@ rtl/core/three_band_biquad_equalizer_unit.sv @@
// Three-band cascaded direct form I biquad equalizer, top level.
// An audio transfer runs eight microcode steps a band on one shared multiplier, and its result
// then shows on out_tvalid; no new item is taken until the sequencer is idle again, and an
// unread result holds the last step. Coefficient writes are also taken only while idle.
// Reset (rst_n low, synchronous): sequencer idle, output empty, every coefficient and
// history entry reads as zero, so the output stays silent until coefficients are written.
`default_nettype none

module three_band_biquad_equalizer_unit #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_WIDTH     = 28,
  parameter int COEF_FRAC_BITS = 24,
  parameter int NUM_BANDS      = 3
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic in_tvalid,
  output logic      in_tready,
  // sample_in, coef_index, coef_value (lowest bits first), zero padded to bytes
  input  wire logic [((SAMPLE_WIDTH + $clog2(NUM_BANDS*eq3_pkg::SLOTS_PER_BAND)
                       + COEF_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // mode: 0 audio sample, 1 coefficient write
  input  wire logic [0:0] in_tuser,

  output logic      out_tvalid,
  input  wire logic out_tready,
  // sample_out, zero padded to bytes
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // clipped
  output logic [0:0] out_tuser
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int NC  = NUM_BANDS * eq3_pkg::SLOTS_PER_BAND;
  localparam int IW  = $clog2(NC);
  localparam int BW  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  // Unpack the input item.
  logic                 in_mode;
  logic signed [SW-1:0] in_sample;
  logic [IW-1:0]        in_index;
  logic signed [CW-1:0] in_coef;

  assign in_mode   = in_tuser[0];
  assign in_sample = $signed(in_tdata[SW-1:0]);
  assign in_index  = in_tdata[SW+IW-1:SW];
  assign in_coef   = $signed(in_tdata[SW+IW+CW-1:SW+IW]);

  logic                 busy, done, hold;
  logic                 in_xfer, start, cw_en;
  eq3_pkg::uword_t      ctrl;
  logic [BW-1:0]        band;
  logic signed [SW-1:0] y_out;
  logic                 clip_out;

  logic                 out_valid_r;
  logic [SW-1:0]        out_sample_r;
  logic                 out_clip_r;

  // Take new items only while the sequencer is idle; a result waiting in the
  // output register does not block the input side.
  assign in_tready = !busy;
  assign in_xfer   = in_tvalid && in_tready;
  assign start     = in_xfer && !in_mode;
  // Drop coefficient writes whose index lies past the last band.
  assign cw_en     = in_xfer && in_mode && (IW'(NC - 1) >= in_index);

  // Hold the final rounding step while the previous result is still unread.
  assign hold = out_valid_r && !out_tready;

  eq3_seq #(.NUM_BANDS(NUM_BANDS)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .hold  (hold),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl),
    .band  (band)
  );

  eq3_dp #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .NUM_BANDS      (NUM_BANDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .band     (band),
    .start    (start),
    .sample   (in_sample),
    .cw_en    (cw_en),
    .cw_addr  (in_index),
    .cw_data  (in_coef),
    .y_out    (y_out),
    .clip_out (clip_out)
  );

  // Output register: load on the last band's rounding step, clear on transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample_r <= y_out;
      out_clip_r   <= clip_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_clip_r;

  always_comb begin
    out_tdata         = '0;
    out_tdata[SW-1:0] = out_sample_r;
  end

endmodule

`default_nettype wire
